/* rtl/tlmmh_pkg.sv */
// Shared constants, types and helper functions of the two-lane multiply-mix hash unit.
`timescale 1ns / 1ps
package tlmmh_pkg;

    localparam logic [31:0] MIX_A_MULT = 32'h5e7e5a17;
    localparam logic [31:0] MIX_B_MULT = 32'h66c4e761;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned LENGTH_W = 32;
    localparam int unsigned HASH_W   = 32;
    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAIL_MUL,
        ST_TAIL_ADD,
        ST_MIX1_MUL,
        ST_MIX1_ADD,
        ST_MIX2_MUL,
        ST_MIX2_ADD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mix_mul;
        logic mix_add;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_last;
        logic item_tail;
        logic out_free;
    } status_t;

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [7:0] byte_at(input logic [63:0] d, input logic [2:0] idx);
        logic [63:0] shifted;
        shifted = d >> {idx, 3'b000};
        return shifted[7:0];
    endfunction

endpackage

/* rtl/tlmmh_ctrl.sv */
// Controller state machine that sequences item loading, mix rounds and result output.
`timescale 1ns / 1ps
module tlmmh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tlmmh_pkg::status_t status,
    output tlmmh_pkg::cmd_t    cmd
);
    import tlmmh_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && status.item_last) begin
                    state_next = status.item_tail ? ST_TAIL_MUL : ST_MIX1_MUL;
                end
            end
            ST_TAIL_MUL: state_next = ST_TAIL_ADD;
            ST_TAIL_ADD: state_next = ST_MIX1_MUL;
            ST_MIX1_MUL: state_next = ST_MIX1_ADD;
            ST_MIX1_ADD: state_next = ST_MIX2_MUL;
            ST_MIX2_MUL: state_next = ST_MIX2_ADD;
            ST_MIX2_ADD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:     cmd.accept = accept;
            ST_TAIL_MUL: cmd.mix_mul = 1'b1;
            ST_TAIL_ADD: cmd.mix_add = 1'b1;
            ST_MIX1_MUL: cmd.mix_mul = 1'b1;
            ST_MIX1_ADD: cmd.mix_add = 1'b1;
            ST_MIX2_MUL: cmd.mix_mul = 1'b1;
            ST_MIX2_ADD: cmd.mix_add = 1'b1;
            ST_EMIT:     cmd.load_out = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

/* rtl/tlmmh_datapath.sv */
// Datapath: hash lanes, seed register, mix multiplier stage and output register.
`timescale 1ns / 1ps
module tlmmh_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tlmmh_pkg::DATA_W-1:0]      data_bytes,
    input  logic [tlmmh_pkg::COUNT_W-1:0]     valid_bytes,
    input  logic                              first_item,
    input  logic                              last_item,
    input  logic [tlmmh_pkg::LENGTH_W-1:0]    message_length,
    input  logic                              cfg_we,
    input  logic [31:0]                       cfg_data,
    input  tlmmh_pkg::cmd_t                   cmd,
    output tlmmh_pkg::status_t                status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tlmmh_pkg::HASH_W-1:0]      hash_value
);
    import tlmmh_pkg::*;

    logic [31:0] lane_a_reg, lane_a_next;
    logic [31:0] lane_b_reg, lane_b_next;
    logic [31:0] seed_reg;
    logic [63:0] prod_a_reg;
    logic [31:0] prod_b_reg;
    logic [31:0] hash_reg;
    logic        out_valid_reg;

    logic [COUNT_W-1:0] count_sat;
    logic [COUNT_W-1:0] count;
    logic               is_full;
    logic               is_tail;
    logic [31:0]        w0, w1;
    logic [31:0]        a_start, b_start;
    logic [31:0]        full_a, full_b;
    logic [2:0]         hw_pos, byte_pos;
    logic [15:0]        halfword;
    logic [31:0]        tail_v1, tail_v;
    logic [31:0]        mix_b;

    // Item decode: a non-last item always counts as eight bytes.
    assign count_sat = (valid_bytes > FULL_COUNT) ? FULL_COUNT : valid_bytes;
    assign count     = last_item ? count_sat : FULL_COUNT;
    assign is_full   = count[3];
    assign is_tail   = !count[3] && (count != '0);

    assign w0 = data_bytes[31:0];
    assign w1 = data_bytes[63:32];

    assign a_start = first_item ? message_length : lane_a_reg;
    assign b_start = first_item ? seed_reg : lane_b_reg;

    assign full_a = swap32(32'((a_start ^ w0) * MIX_A_MULT));
    assign full_b = swap32(32'((b_start ^ w1) * MIX_B_MULT));

    // Tail value: optional halfword followed by an optional trailing byte.
    assign hw_pos   = count[2] ? 3'd4 : 3'd0;
    assign halfword = {byte_at(data_bytes, hw_pos + 3'd1), byte_at(data_bytes, hw_pos)};
    assign tail_v1  = count[1] ? {16'd0, halfword} : 32'd0;
    assign byte_pos = hw_pos + (count[1] ? 3'd2 : 3'd0);
    assign tail_v   = count[0] ? {tail_v1[23:0], byte_at(data_bytes, byte_pos)} : tail_v1;

    assign mix_b = prod_b_reg + prod_a_reg[31:0];

    always_comb begin
        lane_a_next = lane_a_reg;
        lane_b_next = lane_b_reg;
        if (cmd.accept) begin
            if (is_full) begin
                lane_a_next = full_a;
                lane_b_next = full_b;
            end else if (is_tail) begin
                lane_a_next = count[2] ? (a_start ^ w0) : a_start;
                lane_b_next = b_start ^ tail_v;
            end else begin
                lane_a_next = a_start;
                lane_b_next = b_start;
            end
        end else if (cmd.mix_add) begin
            lane_b_next = mix_b;
            lane_a_next = mix_b ^ prod_a_reg[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_a_reg    <= '0;
            lane_b_reg    <= '0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
            if (cfg_we) begin
                seed_reg <= cfg_data;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mix_mul) begin
            prod_a_reg <= 64'(lane_a_reg) * 64'(MIX_A_MULT);
            prod_b_reg <= 32'(lane_b_reg * MIX_B_MULT);
        end
        if (cmd.load_out) begin
            hash_reg <= lane_a_reg;
        end
    end

    assign status.item_last = last_item;
    assign status.item_tail = is_tail;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

/* rtl/two_lane_multiply_mix_hash32_unit.sv */
// Top level of the two-lane multiply-mix 32-bit hash unit.
//
// Usage: a message is streamed in on the s_ channel as words of eight bytes.
// The word that carries tuser (first_item) high loads lane A with the
// message length and lane B with the seed register; the word with tlast high
// closes the message, and its valid_bytes field may give a partial tail of
// one to seven bytes. One 32-bit hash word leaves on the m_ channel for each
// word with tlast high; no other word produces output.
// The user must write the seed through the cfg_ channel only while the unit
// is idle; the unit itself does not enforce this. Words without tlast stream
// at eight bytes per cycle while the unit is idle. A closing word takes the
// unit through a tail round when it has a partial tail, then the mix rounds,
// each a multiply step and an add step through the one shared mix stage, and
// a final step that moves the hash into the output register once it is free;
// s_tready stays low from the taking of the closing word until that move. If
// the receiver stalls, the hash waits in the output register and the next
// message's words are still accepted; a further closing word is taken and
// mixed, but the unit then holds s_tready low until the output register is
// free. Reset (aresetn low, synchronous) clears both lanes, the seed and the
// output valid flag.
`timescale 1ns / 1ps
module two_lane_multiply_mix_hash32_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data,     // seed_value
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_bytes [63:0], valid_bytes [67:64], message_length [99:68], zero [103:100]
    input  logic [tlmmh_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,      // last_item
    input  logic                                s_tuser,      // first_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tlmmh_pkg::M_TDATA_W-1:0]     m_tdata       // hash_value [31:0]
);
    import tlmmh_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The seed register can take a write in every cycle.
    assign cfg_ready = 1'b1;

    tlmmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlmmh_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .data_bytes     (s_tdata[63:0]),
        .valid_bytes    (s_tdata[67:64]),
        .first_item     (s_tuser),
        .last_item      (s_tlast),
        .message_length (s_tdata[99:68]),
        .cfg_we         (cfg_valid),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .hash_value     (m_tdata)
    );

endmodule

/* dv/tlmmh_hash_checker.sv */
// Checker that predicts and compares the hash words of the two-lane multiply-mix unit.
`timescale 1ns / 1ps
module tlmmh_hash_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [31:0]                         cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [tlmmh_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tlmmh_pkg::M_TDATA_W-1:0]     m_tdata,
    output int                                  mismatch_count,
    output int                                  hashes_owed
);
    import tlmmh_pkg::*;

    logic [31:0] lane_a_q = '0;
    logic [31:0] lane_b_q = '0;
    logic [31:0] seed_q   = '0;
    logic [31:0] hash_expected_q[$];

    function automatic logic [31:0] reverse_bytes(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) r[8*i +: 8] = x[8*(3-i) +: 8];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One mix round through the full 64-bit product of lane A.
    task automatic mix_lanes();
        logic [63:0] p;
        p = {32'd0, lane_a_q} * {32'd0, MIX_A_MULT};
        lane_b_q = lane_b_q * MIX_B_MULT + p[31:0];
        lane_a_q = lane_b_q ^ p[63:32];
    endtask

    task automatic absorb_word(input logic [63:0] d, input logic [3:0] cnt_in,
                               input logic first, input logic last,
                               input logic [31:0] len);
        logic [3:0]  cnt;
        logic [31:0] v;
        int          c;
        cnt = (cnt_in > FULL_COUNT) ? FULL_COUNT : cnt_in;
        if (!last) cnt = FULL_COUNT;
        if (first) begin
            lane_a_q = len;
            lane_b_q = seed_q;
        end
        if (cnt == FULL_COUNT) begin
            lane_a_q = reverse_bytes((lane_a_q ^ d[31:0]) * MIX_A_MULT);
            lane_b_q = reverse_bytes((lane_b_q ^ d[63:32]) * MIX_B_MULT);
        end else if (cnt != 0) begin
            c = 0;
            v = '0;
            if (cnt[2]) begin
                lane_a_q ^= d[31:0];
                c = 4;
            end
            if (cnt[1]) begin
                v = {16'd0, d[8*c+8 +: 8], d[8*c +: 8]};
                c += 2;
            end
            if (cnt[0]) v = {v[23:0], d[8*c +: 8]};
            lane_b_q ^= v;
            mix_lanes();
        end
        if (last) begin
            mix_lanes();
            mix_lanes();
            hash_expected_q.push_back(lane_a_q);
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        logic [31:0] want;
        if (!aresetn) begin
            lane_a_q       = '0;
            lane_b_q       = '0;
            seed_q         = '0;
            mismatch_count = 0;
            hash_expected_q.delete();
        end else begin
            // A hash leaving now can never belong to a word taken at this same edge.
            if (m_tvalid && m_tready) begin
                if (hash_expected_q.size() == 0) begin
                    report_mismatch($sformatf("hash word %08h arrived with none expected",
                                              m_tdata));
                end else begin
                    want = hash_expected_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("hash_value %08h, expected %08h",
                                                  m_tdata, want));
                end
            end
            if (cfg_valid && cfg_ready) seed_q = cfg_data;
            if (s_tvalid && s_tready)
                absorb_word(s_tdata[63:0], s_tdata[67:64], s_tuser, s_tlast,
                            s_tdata[99:68]);
        end
        hashes_owed = hash_expected_q.size();
    end

endmodule

/* dv/two_lane_multiply_mix_hash32_unit_tb.sv */
// Testbench top: stimulus, flow control and verdict for the two-lane multiply-mix hash unit.
`timescale 1ns / 1ps
module two_lane_multiply_mix_hash32_unit_tb;
    import tlmmh_pkg::*;

    // Generous bound: every closing word may sit behind a slow receiver and a sender gap.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORDS_PER_PHASE = 450;
    localparam int SETTLE_CYCLES   = 12;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [31:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int mismatch_count;
    int hashes_owed;
    int words_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_left = 0;

    two_lane_multiply_mix_hash32_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tlmmh_hash_checker i_hash_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .hashes_owed    (hashes_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The run is abandoned if it outlives the cycle limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // The receiver changes its manner at random: always ready, coin toss,
    // mostly stalled, or alternating. The always-ready stretches give runs with no stall.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_tready <= ~m_tready;
            end
        endcase
    end

    // Sends one word. Words go out in bursts; between bursts the sender may rest, so gaps
    // land on every phase of the unit's closing sequence. The handshake is judged at the
    // falling edge, where both sides are settled, and the task returns on the rising edge
    // that takes the word.
    task automatic send_word(input logic [63:0] d, input logic [3:0] cnt,
                             input logic first, input logic last,
                             input logic [31:0] len);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, len, cnt, d};
        s_tlast  <= last;
        s_tuser  <= first;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        words_sent++;
    endtask

    // Holds the sender back until every hash owed has been taken and the unit has
    // had time to settle.
    task automatic wait_for_drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (hashes_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A well-formed message with random content. Lengths are mostly short so that
    // closing words, and hence hashes, are frequent. The length field sometimes
    // disagrees with the bytes sent, and middle words now and then carry a stray count.
    task automatic send_message();
        int          nbytes;
        int          tail;
        int          nwords;
        logic [31:0] len;
        logic [3:0]  cnt;
        nbytes = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
        tail   = nbytes % 8;
        nwords = nbytes / 8 + ((tail != 0 || nbytes == 0) ? 1 : 0);
        len    = ($urandom_range(0, 3) == 0) ? $urandom() : 32'(nbytes);
        for (int i = 0; i < nwords; i++) begin
            if (i == nwords - 1) begin
                if (nbytes == 0)
                    cnt = 4'd0;
                else if (tail != 0)
                    cnt = 4'(tail);
                else
                    cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15)) : FULL_COUNT;
            end else begin
                cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : FULL_COUNT;
            end
            send_word({$urandom(), $urandom()}, cnt, i == 0, i == nwords - 1, len);
        end
    endtask

    task automatic send_random_phase();
        int stop_at;
        stop_at = words_sent + WORDS_PER_PHASE;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // Noise: flags and count at random, so messages break and restart.
                send_word({$urandom(), $urandom()}, 4'($urandom_range(0, 15)),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, $urandom());
            end else begin
                send_message();
            end
            if ($urandom_range(0, 39) == 0) wait_for_drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words, with the seed at its reset value of zero.
        // A closing word with no opening word works on the lanes straight out of reset.
        send_word(64'd0, FULL_COUNT, 1'b0, 1'b1, 32'd0);
        // Empty messages, with the smallest and largest length.
        send_word(64'd0, 4'd0, 1'b1, 1'b1, 32'd0);
        send_word({$urandom(), $urandom()}, 4'd0, 1'b1, 1'b1, 32'hffff_ffff);
        // One full word, all ones and all zeros.
        send_word(64'hffff_ffff_ffff_ffff, FULL_COUNT, 1'b1, 1'b1, 32'hffff_ffff);
        send_word(64'd0, FULL_COUNT, 1'b1, 1'b1, 32'd8);
        // Every tail length from one to seven bytes.
        for (int t = 1; t < 8; t++)
            send_word({$urandom(), $urandom()}, 4'(t), 1'b1, 1'b1, 32'(t));
        // Counts above eight are taken as a full word.
        send_word({$urandom(), $urandom()}, 4'd15, 1'b1, 1'b1, 32'd8);
        send_word(64'd0, 4'd9, 1'b1, 1'b1, 32'd8);
        // A short count on a word that is not last is ignored; then an empty last word.
        send_word({$urandom(), $urandom()}, 4'd3, 1'b1, 1'b0, 32'd11);
        send_word({$urandom(), $urandom()}, 4'd0, 1'b0, 1'b1, 32'd0);
        // Words after a finished message carry on from the finished lanes.
        send_word({$urandom(), $urandom()}, FULL_COUNT, 1'b0, 1'b0, 32'd0);
        send_word({$urandom(), $urandom()}, 4'd6, 1'b0, 1'b1, 32'd0);
        // A length that does not match the bytes that follow.
        send_word({$urandom(), $urandom()}, FULL_COUNT, 1'b1, 1'b0, 32'd100);
        send_word(64'hffff_ffff_ffff_ffff, 4'd4, 1'b0, 1'b1, 32'd0);
        send_word(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1, 1'b1, 32'd7);
        send_word(64'h8000_0000_0000_0001, 4'd5, 1'b1, 1'b1, 32'd5);
        wait_for_drain();

        // Random phases under several seeds, both extremes among them.
        write_seed(32'hffff_ffff);
        send_random_phase();
        wait_for_drain();
        write_seed($urandom());
        send_random_phase();
        wait_for_drain();
        write_seed(32'h0000_0000);
        send_random_phase();
        wait_for_drain();
        write_seed($urandom());
        send_random_phase();

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/tlmmh_pkg.sv
rtl/tlmmh_ctrl.sv
rtl/tlmmh_datapath.sv
rtl/two_lane_multiply_mix_hash32_unit.sv
dv/tlmmh_hash_checker.sv
dv/two_lane_multiply_mix_hash32_unit_tb.sv
